// File: design/rbsi_pkg.sv
// Shared types and constants for the ray versus box slab test.
`default_nettype none
package rbsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int N_AXES    = 3;
    localparam int DAT_W     = 32;
    localparam int SIZE_W    = 31;
    localparam int Q_W       = 31;
    localparam int MAG_W     = 34;
    localparam int DEN_W     = 33;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int CMP_W     = (DVD_W > DEN_W + Q_W) ? DVD_W : DEN_W + Q_W;
    localparam int PIPE_LAT  = Q_W + 2;
    localparam int ADDR_W    = 5;

    localparam logic signed [DAT_W-1:0] TMAX = {1'b0, {(DAT_W-1){1'b1}}};
    localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        REG_SIZE_X   = 3'd0,
        REG_SIZE_Y   = 3'd1,
        REG_SIZE_Z   = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                    miss;
        logic                    skip;
        logic signed [DAT_W-1:0] lo;
        logic signed [DAT_W-1:0] hi;
    } lane_res_t;

endpackage
`default_nettype wire

// File: design/rbsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating.
`default_nettype none
module rbsi_div
    import rbsi_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [DVD_W-1:0]        dvd,
    input  wire logic [DEN_W-1:0]        den,
    input  wire logic                    neg,
    output logic signed [DAT_W-1:0]      quo
);

    logic [CMP_W-1:0] r_reg   [0:Q_W-1];
    logic [DEN_W-1:0] den_reg [0:Q_W-1];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             ovf_reg [0:Q_W];
    logic             neg_reg [0:Q_W];
    logic [Q_W-1:0]   q_sat;
    logic [DAT_W-1:0] q_ext;

    // quotient of 2^Q_W or more saturates
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= CMP_W'(dvd);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= CMP_W'(dvd) >= (CMP_W'(den) << Q_W);
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        localparam int SH = Q_W - k;
        logic [CMP_W-1:0] sub;
        logic             ge;
        assign sub = CMP_W'(den_reg[k-1]) << SH;
        assign ge  = r_reg[k-1] >= sub;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]     <= q_reg[k-1] | (Q_W'(ge) << SH);
                ovf_reg[k]   <= ovf_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
            end
        end

        if (k < Q_W) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k]   <= ge ? r_reg[k-1] - sub : r_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign q_sat = ovf_reg[Q_W] ? TMAX[Q_W-1:0] : q_reg[Q_W];
    assign q_ext = DAT_W'({1'b0, q_sat});
    assign quo   = neg_reg[Q_W] ? -$signed(q_ext) : $signed(q_ext);

endmodule
`default_nettype wire

// File: design/rbsi_lane.sv
// One axis lane: slab numerators, two dividers, ordered entry and exit.
`default_nettype none
module rbsi_lane
    import rbsi_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [DAT_W-1:0]  origin,
    input  wire logic signed [DAT_W-1:0]  dir,
    input  wire logic [SIZE_W-1:0]        size,
    input  wire logic signed [DAT_W-1:0]  center,
    output lane_res_t                     res
);

    logic signed [MAG_W:0]   p2;
    logic signed [MAG_W:0]   num0;
    logic signed [MAG_W:0]   num1;
    logic signed [MAG_W:0]   s_ext;
    logic [MAG_W:0]          p2_abs;
    logic [MAG_W:0]          n0_abs;
    logic [MAG_W:0]          n1_abs;
    logic signed [DEN_W-1:0] d2;
    logic [DEN_W-1:0]        d2_abs;

    logic [MAG_W-1:0] mag0_reg;
    logic [MAG_W-1:0] mag1_reg;
    logic [DEN_W-1:0] dm_reg;
    logic             neg0_reg;
    logic             neg1_reg;
    logic             par_reg   [0:Q_W+1];
    logic             pmiss_reg [0:Q_W+1];
    logic signed [DAT_W-1:0] t0;
    logic signed [DAT_W-1:0] t1;

    assign s_ext  = $signed({{(MAG_W+1-SIZE_W){1'b0}}, size});
    assign p2     = ($signed({{(MAG_W+1-DAT_W){origin[DAT_W-1]}}, origin})
                   - $signed({{(MAG_W+1-DAT_W){center[DAT_W-1]}}, center})) <<< 1;
    assign num0   = -s_ext - p2;
    assign num1   = s_ext - p2;
    assign p2_abs = p2[MAG_W] ? -p2 : p2;
    assign n0_abs = num0[MAG_W] ? -num0 : num0;
    assign n1_abs = num1[MAG_W] ? -num1 : num1;
    assign d2     = {dir, 1'b0};
    // -2^32 negates to the same pattern, read unsigned as 2^32
    assign d2_abs = d2[DEN_W-1] ? -d2 : d2;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag0_reg     <= n0_abs[MAG_W-1:0];
            mag1_reg     <= n1_abs[MAG_W-1:0];
            dm_reg       <= d2_abs;
            neg0_reg     <= num0[MAG_W] ^ dir[DAT_W-1];
            neg1_reg     <= num1[MAG_W] ^ dir[DAT_W-1];
            par_reg[0]   <= (dir == '0);
            pmiss_reg[0] <= p2_abs[MAG_W-1:0] > MAG_W'(size);
        end
    end

    for (genvar k = 1; k <= Q_W + 1; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                par_reg[k]   <= par_reg[k-1];
                pmiss_reg[k] <= pmiss_reg[k-1];
            end
        end
    end

    rbsi_div u_div0 (
        .aclk (aclk),
        .en   (en),
        .dvd  ({mag0_reg, {FRAC_BITS{1'b0}}}),
        .den  (dm_reg),
        .neg  (neg0_reg),
        .quo  (t0)
    );

    rbsi_div u_div1 (
        .aclk (aclk),
        .en   (en),
        .dvd  ({mag1_reg, {FRAC_BITS{1'b0}}}),
        .den  (dm_reg),
        .neg  (neg1_reg),
        .quo  (t1)
    );

    always_comb begin
        res.skip = par_reg[Q_W+1];
        res.miss = par_reg[Q_W+1] & pmiss_reg[Q_W+1];
        res.lo   = (t0 > t1) ? t1 : t0;
        res.hi   = (t0 > t1) ? t0 : t1;
    end

endmodule
`default_nettype wire

// File: design/rbsi_merge.sv
// Intersects the per-axis intervals into hit and entry parameter.
`default_nettype none
module rbsi_merge
    import rbsi_pkg::*;
(
    input  wire lane_res_t           lanes [0:N_AXES-1],
    output logic                     hit,
    output logic [SIZE_W-1:0]        entry
);

    logic signed [DAT_W-1:0] tmin;
    logic signed [DAT_W-1:0] tmax;
    logic                    miss;

    always_comb begin
        tmin = '0;
        tmax = TMAX;
        miss = 1'b0;
        for (int a = 0; a < N_AXES; a++) begin
            miss = miss | lanes[a].miss;
            if (!lanes[a].skip) begin
                if (lanes[a].lo > tmin) begin
                    tmin = lanes[a].lo;
                end
                if (lanes[a].hi < tmax) begin
                    tmax = lanes[a].hi;
                end
            end
        end
        hit   = !miss && (tmin <= tmax);
        entry = hit ? tmin[SIZE_W-1:0] : '0;
    end

endmodule
`default_nettype wire

// File: design/ray_box_slab_intersect.sv
// Top level: ray versus axis-aligned box slab test, three axis lanes and a merge.
// Usage:
//   Rays arrive on the s_ stream, one per transfer; s_tdata holds origin x, y, z then
//   direction x, y, z (signed Q16.16). Each ray yields exactly one result transfer on the
//   m_ stream: bit 0 is hit, bits 31:1 the entry parameter (0 on a miss).
//   Box size and centre are set through the APB port at byte addresses 0x00..0x14;
//   write them only while no ray is in flight.
//   Each accepted ray passes one setup stage, a 32-stage pipelined divider (one overflow
//   check, then one quotient bit per stage) and the output register. Throughput is one ray
//   per cycle while s_tready stays high.
//   When m_tready is low the result waits in the output register and one more result
//   goes to a skid register; s_tready then drops and the whole pipeline holds until the
//   skid entry drains.
//   Reset (aresetn low, synchronous) empties the pipeline and sets the box to a unit cube
//   centred at the origin.
`default_nettype none
module ray_box_slab_intersect
    import rbsi_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest bits first)
    input  wire logic [6*DAT_W-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // hit, entry_param (lowest bits first)
    output logic [DAT_W-1:0]           m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [SIZE_W-1:0]       size_reg   [0:N_AXES-1];
    logic signed [DAT_W-1:0] center_reg [0:N_AXES-1];
    logic                    vld_reg    [0:PIPE_LAT-1];
    lane_res_t               lanes      [0:N_AXES-1];
    logic                    out_valid_reg;
    logic [DAT_W-1:0]        out_data_reg;
    logic                    skid_valid_reg;
    logic [DAT_W-1:0]        skid_data_reg;
    logic                    en;
    logic                    hit;
    logic [SIZE_W-1:0]       entry;
    logic [DAT_W-1:0]        res_data;
    logic                    res_valid;
    logic                    wr_en;
    reg_idx_t                idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < N_AXES; a++) begin
                size_reg[a]   <= SIZE_RST;
                center_reg[a] <= '0;
            end
        end else if (wr_en) begin
            unique case (idx)
                REG_SIZE_X:   size_reg[0]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:   size_reg[1]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z:   size_reg[2]   <= pwdata[SIZE_W-1:0];
                REG_CENTER_X: center_reg[0] <= pwdata;
                REG_CENTER_Y: center_reg[1] <= pwdata;
                REG_CENTER_Z: center_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SIZE_X:   prdata = 32'(size_reg[0]);
            REG_SIZE_Y:   prdata = 32'(size_reg[1]);
            REG_SIZE_Z:   prdata = 32'(size_reg[2]);
            REG_CENTER_X: prdata = center_reg[0];
            REG_CENTER_Y: prdata = center_reg[1];
            REG_CENTER_Z: prdata = center_reg[2];
            default:      prdata = '0;
        endcase
    end

    // pipeline moves whenever the skid slot is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < PIPE_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    for (genvar a = 0; a < N_AXES; a++) begin : g_lane
        rbsi_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .origin (s_tdata[a*DAT_W +: DAT_W]),
            .dir    (s_tdata[(a+N_AXES)*DAT_W +: DAT_W]),
            .size   (size_reg[a]),
            .center (center_reg[a]),
            .res    (lanes[a])
        );
    end

    rbsi_merge u_merge (
        .lanes (lanes),
        .hit   (hit),
        .entry (entry)
    );

    assign res_data  = {entry, hit};
    assign res_valid = vld_reg[PIPE_LAT-1] & en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
                out_data_reg  <= res_data;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
